[rtl/core/t8cpu_pkg.sv]
// package for the tiny 8-bit cpu core: sizes, codes and sequencer states
`default_nettype none
package t8cpu_pkg;
	localparam int MEM_BYTES = 65536;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int REG_COUNT = 16;
	localparam int REG_AW    = $clog2(REG_COUNT);
	localparam logic [7:0] MEM_RESET = 8'he0;
	localparam logic [7:0] BYTE_ALL1 = 8'hff;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_EXEC = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam logic [3:0] OPC_VAL = 4'h0;
	localparam logic [3:0] OPC_MATH = 4'h1;
	localparam logic [3:0] OPC_COND = 4'h2;
	localparam logic [3:0] OPC_JUMP = 4'h3;
	localparam logic [3:0] OPC_LOAD = 4'h6;
	localparam logic [3:0] OPC_STORE = 4'h7;
	localparam logic [3:0] OPC_OVR = 4'ha;
	localparam logic [3:0] OPC_PRINT = 4'hb;
	localparam logic [3:0] OPC_HALT = 4'he;

	localparam logic [3:0] M_ADD = 4'h0;
	localparam logic [3:0] M_SUB = 4'h1;
	localparam logic [3:0] M_DIV = 4'h2;
	localparam logic [3:0] M_MUL = 4'h3;
	localparam logic [3:0] M_INC = 4'h4;
	localparam logic [3:0] M_DEC = 4'h5;
	localparam logic [3:0] M_AND = 4'h6;
	localparam logic [3:0] M_OR = 4'h7;
	localparam logic [3:0] M_XOR = 4'h8;
	localparam logic [3:0] M_SHR = 4'h9;
	localparam logic [3:0] M_SHL = 4'ha;
	localparam logic [3:0] M_MOD = 4'hb;
	localparam logic [3:0] M_COPY = 4'hc;

	localparam logic [3:0] C_EQ = 4'h0;
	localparam logic [3:0] C_NE = 4'h1;
	localparam logic [3:0] C_GT = 4'h2;
	localparam logic [3:0] C_GE = 4'h3;
	localparam logic [3:0] C_LT = 4'h4;
	localparam logic [3:0] C_LE = 4'h5;
	localparam logic [3:0] C_IS0 = 4'h6;
	localparam logic [3:0] C_NOT0 = 4'h7;
	localparam logic [3:0] C_GET = 4'h8;

	// carry left for the next instruction
	typedef enum logic [1:0] {
		CY_ZERO,
		CY_PLUS,
		CY_MINUS,
		CY_BYTE
	} carry_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_F0,
		ST_F1,
		ST_F1W,
		ST_DEC,
		ST_DIV,
		ST_LDW,
		ST_LDD,
		ST_DONE
	} state_t;

	// request to the divider and its answer
	typedef struct packed {
		logic       go;
		logic [7:0] num;
		logic [7:0] den;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quo;
		logic [7:0] rem;
	} div_rsp_t;
endpackage
`default_nettype wire

[rtl/core/tiny_8bit_cpu_core.sv]
// top level of the tiny 8-bit cpu core: sequencer, register file, memory
//
// channel   direction  signals
// request   in         start, action, load_address, load_data
// result    out        busy, done, halted, exit_status, print_valid, print_char, program_counter
//
// after reset a clearing pass writes 0xE0 to all MEM_BYTES bytes, busy is high meanwhile.
// a load or start passes the first fetch state and the result state; an instruction
// runs two fetch reads of the memory read port, decode with writeback, and result; a memory
// load adds a wait and a register write, and divide or modulo by a nonzero value waits on
// the 8-step serial divider. results show for one cycle on done; the receiver cannot stall.
`default_nettype none
module tiny_8bit_cpu_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] load_address,
	input  wire logic [7:0]  load_data,
	output logic             done,
	output logic             halted,
	output logic [7:0]       exit_status,
	output logic             print_valid,
	output logic [7:0]       print_char,
	output logic [15:0]      program_counter
);
	import t8cpu_pkg::*;

	state_t state_q, state_d;
	logic [7:0]  mem [MEM_BYTES];
	logic [7:0]  rf_q [REG_COUNT];
	logic [7:0]  rd_q;
	logic [MEM_AW-1:0] clr_q;
	logic [15:0] pc_q;
	carry_kind_t cyk_q;
	logic [7:0]  cyb_q;
	logic [7:0]  cmp_q, exit_q, b0_q, b1_q, pch_q, ldat_q;
	logic        halt_q, pv_q;
	logic [1:0]  act_q;
	logic [15:0] addr_q;

	// memory port control
	logic              mwe, mre;
	logic [MEM_AW-1:0] mwa, mra;
	logic [7:0]        mwd;

	div_req_t dreq;
	div_rsp_t drsp;

	logic [3:0] opc, fd, fa, fb;
	logic [7:0] ra, rb, rdd;
	assign opc = b0_q[7:4];
	assign fd  = b0_q[3:0];
	assign fa  = b1_q[7:4];
	assign fb  = b1_q[3:0];
	assign ra  = rf_q[fa];
	assign rb  = rf_q[fb];
	assign rdd = rf_q[fd];

	t8cpu_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// byte memory with one write port and one registered read port
	always_ff @(posedge clk) begin
		if (mwe)
			mem[mwa] <= mwd;
		if (mre)
			rd_q <= mem[mra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (&clr_q) state_d = ST_IDLE;
			ST_IDLE: begin
				if (start)
					state_d = ST_F0;
			end
			ST_F0:   state_d = (act_q == ACT_EXEC && !halt_q) ? ST_F1 : ST_DONE;
			ST_F1:   state_d = ST_F1W;
			ST_F1W:  state_d = ST_DEC;
			ST_DEC: begin
				if (opc == OPC_MATH && (fd == M_DIV || fd == M_MOD) && rb != 8'd0)
					state_d = ST_DIV;
				else if (opc == OPC_LOAD)
					state_d = ST_LDW;
				else
					state_d = ST_DONE;
			end
			ST_DIV:  if (drsp.done) state_d = ST_DONE;
			ST_LDW:  state_d = ST_LDD;
			ST_LDD:  state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory access per state
	always_comb begin
		mwe = 1'b0;
		mre = 1'b0;
		mwa = clr_q;
		mwd = MEM_RESET;
		mra = pc_q[MEM_AW-1:0];
		case (state_q)
			ST_CLEAR: mwe = 1'b1;
			ST_F0: begin
				if (act_q == ACT_LOAD) begin
					mwe = 1'b1;
					mwa = addr_q[MEM_AW-1:0];
					mwd = ldat_q;
				end
				mre = 1'b1;
			end
			ST_F1: begin
				mre = 1'b1;
				mra = MEM_AW'(pc_q + 16'd1);
			end
			ST_DEC: begin
				if (opc == OPC_LOAD) begin
					mre = 1'b1;
					mra = MEM_AW'({ra, rb});
				end else if (opc == OPC_STORE) begin
					mwe = 1'b1;
					mwa = MEM_AW'({ra, rb});
					mwd = rdd;
				end
			end
			default: ;
		endcase
	end

	assign dreq.go  = state_q == ST_DEC && state_d == ST_DIV;
	assign dreq.num = ra;
	assign dreq.den = rb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (state_q == ST_CLEAR)
			clr_q <= clr_q + 1'b1;
	end

	// capture the request and the two fetched instruction bytes
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			act_q  <= action;
			addr_q <= load_address;
			ldat_q <= load_data;
		end
		if (state_q == ST_F1)
			b0_q <= rd_q;
		if (state_q == ST_DEC)
			b1_q <= b1_q;
		if (state_q == ST_F1W)
			b1_q <= rd_q;
	end

	// architectural state and the execute step
	logic [8:0]  sum;
	logic [15:0] prod;
	logic [7:0]  ares;
	carry_kind_t akind;
	logic        owr;
	assign sum  = {1'b0, ra} + {1'b0, rb};
	assign prod = ra * rb;

	always_comb begin
		akind = CY_ZERO;
		owr   = 1'b1;
		case (fd)
			M_ADD: begin ares = sum[7:0]; akind = sum[8] ? CY_PLUS : CY_ZERO; end
			M_SUB: begin ares = ra - rb; akind = (rb > ra) ? CY_MINUS : CY_ZERO; end
			M_MUL: begin ares = prod[7:0]; akind = CY_BYTE; end
			M_INC: begin ares = ra + 8'd1; akind = (ra == BYTE_ALL1) ? CY_PLUS : CY_ZERO; end
			M_DEC: begin ares = ra - 8'd1; akind = (ra == 8'd0) ? CY_MINUS : CY_ZERO; end
			M_AND: ares = ra & rb;
			M_OR:  ares = ra | rb;
			M_XOR: ares = ra ^ rb;
			M_SHR: ares = (rb >= 8'd8) ? 8'd0 : ra >> rb[2:0];
			M_SHL: ares = (rb >= 8'd8) ? 8'd0 : ra << rb[2:0];
			M_DIV, M_MOD: begin ares = BYTE_ALL1; owr = rb == 8'd0; end
			M_COPY: ares = rb;
			default: ares = BYTE_ALL1;
		endcase
	end

	logic [8:0] ovs;
	assign ovs = {1'b0, rdd} + {1'b0, cyb_q};

	// taken jump and the carry kind left by this instruction
	logic        jmp_take;
	carry_kind_t cyk_n;
	assign jmp_take = opc == OPC_JUMP && (fd == 4'd0 || (fd == 4'd1 && cmp_q != 8'd0));

	always_comb begin
		cyk_n = CY_ZERO;
		case (opc)
			OPC_MATH: cyk_n = akind;
			OPC_OVR: begin
				case (cyk_q)
					CY_PLUS:  if (rdd == BYTE_ALL1) cyk_n = CY_PLUS;
					CY_MINUS: if (rdd == 8'd0) cyk_n = CY_MINUS;
					CY_BYTE:  if (ovs[8]) cyk_n = CY_PLUS;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++)
				rf_q[i] <= '0;
			pc_q   <= '0;
			cyk_q  <= CY_ZERO;
			cyb_q  <= '0;
			cmp_q  <= '0;
			halt_q <= 1'b1;
			exit_q <= '0;
			pv_q   <= 1'b0;
			pch_q  <= '0;
		end else begin
			if (state_q == ST_IDLE && start) begin
				pv_q  <= 1'b0;
				pch_q <= '0;
			end
			if (state_q == ST_F0 && act_q == ACT_START) begin
				pc_q   <= '0;
				cyk_q  <= CY_ZERO;
				cmp_q  <= '0;
				halt_q <= 1'b0;
			end
			if (state_q == ST_DIV && drsp.done)
				rf_q[fa] <= (fd == M_DIV) ? drsp.quo : drsp.rem;
			if (state_q == ST_LDD)
				rf_q[fd] <= rd_q;
			if (state_q == ST_DEC) begin
				pc_q  <= jmp_take ? {ra, rb} : pc_q + 16'd2;
				cyk_q <= cyk_n;
				case (opc)
					OPC_VAL: rf_q[fd] <= b1_q;
					OPC_MATH: begin
						if (owr)
							rf_q[fa] <= ares;
						cyb_q <= (akind == CY_BYTE) ? prod[15:8] : 8'd1;
					end
					OPC_COND: begin
						case (fd)
							C_EQ:   cmp_q <= {7'd0, ra == rb};
							C_NE:   cmp_q <= {7'd0, ra != rb};
							C_GT:   cmp_q <= {7'd0, ra > rb};
							C_GE:   cmp_q <= {7'd0, ra >= rb};
							C_LT:   cmp_q <= {7'd0, ra < rb};
							C_LE:   cmp_q <= {7'd0, ra <= rb};
							C_IS0:  cmp_q <= {7'd0, ra == 8'd0};
							C_NOT0: cmp_q <= {7'd0, ra != 8'd0};
							C_GET:  rf_q[fa] <= cmp_q;
							default: cmp_q <= BYTE_ALL1;
						endcase
					end
					OPC_JUMP, OPC_LOAD, OPC_STORE: ;
					OPC_OVR: begin
						case (cyk_q)
							CY_PLUS: begin
								rf_q[fd] <= rdd + 8'd1;
								cyb_q <= 8'd1;
							end
							CY_MINUS: begin
								rf_q[fd] <= rdd - 8'd1;
								cyb_q <= 8'd1;
							end
							CY_BYTE: begin
								rf_q[fd] <= ovs[7:0];
								cyb_q <= 8'd1;
							end
							default: ;
						endcase
					end
					OPC_PRINT: begin
						pv_q  <= 1'b1;
						pch_q <= rdd;
					end
					OPC_HALT: begin
						exit_q <= rdd;
						halt_q <= 1'b1;
					end
					default: begin
						exit_q <= BYTE_ALL1;
						halt_q <= 1'b1;
					end
				endcase
			end
		end
	end

	assign busy            = state_q != ST_IDLE;
	assign done            = state_q == ST_DONE;
	assign halted          = halt_q;
	assign exit_status     = exit_q;
	assign print_valid     = pv_q;
	assign print_char      = pch_q;
	assign program_counter = pc_q;

`ifndef SYNTHESIS
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe not followed by idle");
	a_print_char: assert property (@(posedge clk) disable iff (!arst_n)
		done && !print_valid |-> print_char == 8'd0)
		else $error("print char set without print");
	a_div_only: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide step");
`endif
endmodule
`default_nettype wire

[rtl/core/t8cpu_div.sv]
// bit-serial 8-bit unsigned divider, one quotient bit per cycle
`default_nettype none
module t8cpu_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire t8cpu_pkg::div_req_t req,
	output t8cpu_pkg::div_rsp_t      rsp
);
	import t8cpu_pkg::*;

	logic [7:0] quo_q, den_q;
	logic [8:0] rem_q;
	logic [3:0] cnt_q;
	logic       busy_q;
	logic [8:0] trial;

	// shift in the next numerator bit and try a subtract
	assign trial = {rem_q[7:0], quo_q[7]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.go) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd8;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 4'd1;
			busy_q <= cnt_q != 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[8]) begin
				rem_q <= {1'b0, trial[7:0]};
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= {rem_q[7:0], quo_q[7]};
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	assign rsp.done = busy_q && cnt_q == 4'd1;
	assign rsp.quo  = trial[8] ? {quo_q[6:0], 1'b0} : {quo_q[6:0], 1'b1};
	assign rsp.rem  = trial[8] ? {rem_q[6:0], quo_q[7]} : trial[7:0];
endmodule
`default_nettype wire
